### src/hgm_pkg.sv
// Shared types and codes for the height grid engine.
package hgm_pkg;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Z   = 3'd1;
  localparam logic [2:0] REG_INV_CELL_X = 3'd2;
  localparam logic [2:0] REG_INV_CELL_Z = 3'd3;
  localparam logic [2:0] REG_FALLBACK   = 3'd4;

  localparam logic [1:0] LERP_A     = 2'd0;
  localparam logic [1:0] LERP_B     = 2'd1;
  localparam logic [1:0] LERP_FINAL = 2'd2;

  typedef enum logic [15:0] {
    ST_IDLE  = 16'b0000_0000_0000_0001,
    ST_CLEAR = 16'b0000_0000_0000_0010,
    ST_MULX  = 16'b0000_0000_0000_0100,
    ST_MULZ  = 16'b0000_0000_0000_1000,
    ST_CLAMP = 16'b0000_0000_0001_0000,
    ST_RD    = 16'b0000_0000_0010_0000,
    ST_WR    = 16'b0000_0000_0100_0000,
    ST_Q0    = 16'b0000_0000_1000_0000,
    ST_Q1    = 16'b0000_0001_0000_0000,
    ST_Q2    = 16'b0000_0010_0000_0000,
    ST_Q3    = 16'b0000_0100_0000_0000,
    ST_Q4    = 16'b0000_1000_0000_0000,
    ST_LD    = 16'b0001_0000_0000_0000,
    ST_LM    = 16'b0010_0000_0000_0000,
    ST_LA    = 16'b0100_0000_0000_0000,
    ST_OUT   = 16'b1000_0000_0000_0000
  } state_t;

  typedef struct packed {
    logic       load;
    logic       mul_x;
    logic       mul_z;
    logic       clamp_z;
    logic       clr_wr;
    logic       rd;
    logic [1:0] rd_corner;
    logic       cap;
    logic [1:0] cap_corner;
    logic       wr_ins;
    logic       lerp_d;
    logic       lerp_m;
    logic       lerp_a;
    logic [1:0] lerp_sel;
    logic       res_zero;
  } cmd_t;

  typedef struct packed {
    logic grid_valid;
    logic clr_last;
  } stat_t;

endpackage

### src/height_grid_max_raster_bilinear_top.sv
// Top level of the height grid engine: max-Y insert and bilinear query.
// Usage:
//   Input words are taken on a clock edge with start high and busy low.
//   action 0 clears the grid: busy while the mark memory is swept one
//   row per cycle. action 1 inserts a vertex (mapping multiplies for X
//   and Z, clamp, read, write back). action 2 queries: from accept to the
//   done strobe it runs mapping, four corner reads from the single read
//   port and three blend steps of subtract, multiply, add. A query on an
//   invalid grid strobes done in the cycle after the accept with height 0.
//   action 3 is taken and ignored. One word is in flight at a time;
//   done is high for one cycle with height_value and grid_was_valid,
//   and the receiver cannot stall. Config registers are written through
//   cfg_we/cfg_index/cfg_data; the user must write them only while idle,
//   as the block itself does not enforce it. After reset the block runs
//   the mark sweep with busy high before the first word is taken.
module height_grid_max_raster_bilinear_top #(
  parameter int GRID_SIZE = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  output logic               done,
  output logic signed [31:0] height_value,
  output logic               grid_was_valid,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import hgm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  hgm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .action(action),
    .stat(stat), .cmd(cmd), .busy(busy), .done(done)
  );

  hgm_dp #(.GRID_SIZE(GRID_SIZE)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .height_value(height_value), .grid_was_valid(grid_was_valid)
  );

endmodule

### src/hgm_ram.sv
// Generic simple dual-port RAM with registered read.
module hgm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/hgm_ctrl.sv
// Sequencer for clear, insert and query actions.
module hgm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    action,
  input  hgm_pkg::stat_t stat,
  output hgm_pkg::cmd_t  cmd,
  output logic          busy,
  output logic          done
);
  import hgm_pkg::*;

  state_t     state, state_next;
  logic [1:0] act, act_next;
  logic [1:0] lsel, lsel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      act   <= ACT_CLEAR;
      lsel  <= LERP_A;
    end else begin
      state <= state_next;
      act   <= act_next;
      lsel  <= lsel_next;
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_OUT);

  always_comb begin
    state_next = state;
    act_next   = act;
    lsel_next  = lsel;
    cmd        = '0;
    cmd.lerp_sel = lsel;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          act_next = action;
          unique case (action)
            ACT_CLEAR:  state_next = ST_CLEAR;
            ACT_INSERT: state_next = ST_MULX;
            ACT_QUERY: begin
              if (stat.grid_valid) begin
                state_next = ST_MULX;
              end else begin
                cmd.res_zero = 1'b1;
                state_next   = ST_OUT;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_MULX: begin
        cmd.mul_x  = 1'b1;
        state_next = ST_MULZ;
      end
      ST_MULZ: begin
        cmd.mul_z  = 1'b1;
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.clamp_z = 1'b1;
        state_next  = (act == ACT_INSERT) ? ST_RD : ST_Q0;
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_WR;
      end
      ST_WR: begin
        cmd.wr_ins = 1'b1;
        state_next = ST_IDLE;
      end
      ST_Q0: begin
        cmd.rd        = 1'b1;
        cmd.rd_corner = 2'd0;
        state_next    = ST_Q1;
      end
      ST_Q1: begin
        cmd.rd         = 1'b1;
        cmd.rd_corner  = 2'd1;
        cmd.cap        = 1'b1;
        cmd.cap_corner = 2'd0;
        state_next     = ST_Q2;
      end
      ST_Q2: begin
        cmd.rd         = 1'b1;
        cmd.rd_corner  = 2'd2;
        cmd.cap        = 1'b1;
        cmd.cap_corner = 2'd1;
        state_next     = ST_Q3;
      end
      ST_Q3: begin
        cmd.rd         = 1'b1;
        cmd.rd_corner  = 2'd3;
        cmd.cap        = 1'b1;
        cmd.cap_corner = 2'd2;
        state_next     = ST_Q4;
      end
      ST_Q4: begin
        cmd.cap        = 1'b1;
        cmd.cap_corner = 2'd3;
        lsel_next      = LERP_A;
        state_next     = ST_LD;
      end
      ST_LD: begin
        cmd.lerp_d = 1'b1;
        state_next = ST_LM;
      end
      ST_LM: begin
        cmd.lerp_m = 1'b1;
        state_next = ST_LA;
      end
      ST_LA: begin
        cmd.lerp_a = 1'b1;
        if (lsel == LERP_FINAL) begin
          state_next = ST_OUT;
        end else begin
          lsel_next  = lsel + 2'd1;
          state_next = ST_LD;
        end
      end
      ST_OUT: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### src/hgm_dp.sv
// Datapath: config registers, grid mapping, grid memories and bilinear blend.
module hgm_dp #(
  parameter int GRID_SIZE = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  hgm_pkg::cmd_t       cmd,
  output hgm_pkg::stat_t      stat,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic signed [31:0]  coord_x,
  input  logic signed [31:0]  coord_y,
  input  logic signed [31:0]  coord_z,
  output logic signed [31:0]  height_value,
  output logic                grid_was_valid
);
  import hgm_pkg::*;

  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int IW    = $clog2(GRID_SIZE);
  localparam int AW    = $clog2(CELLS);
  localparam int LW    = IW + 16;
  localparam logic [LW-1:0] LIM  = LW'((GRID_SIZE - 1) * 65536);
  localparam logic [IW-1:0] LAST = IW'(GRID_SIZE - 1);

  logic signed [31:0] origin_x, origin_z, fallback;
  logic        [31:0] inv_x, inv_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_z <= '0;
      inv_x    <= 32'd65536;
      inv_z    <= 32'd65536;
      fallback <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X:   origin_x <= cfg_data;
        REG_ORIGIN_Z:   origin_z <= cfg_data;
        REG_INV_CELL_X: inv_x    <= cfg_data;
        REG_INV_CELL_Z: inv_z    <= cfg_data;
        REG_FALLBACK:   fallback <= cfg_data;
        default: ;
      endcase
    end
  end

  // grid mapping
  logic signed [32:0] dx, dz;
  logic signed [31:0] ycoord;
  logic        [63:0] prod;
  logic        [LW-1:0] lx, lz;
  logic dx_pos, dz_pos;

  function automatic logic [LW-1:0] clamp_coord(input logic [63:0] p, input logic pos);
    logic [LW-1:0] r;
    if (!pos) begin
      r = '0;
    end else if (p[63:16] > 48'(LIM)) begin
      r = LIM;
    end else begin
      r = p[LW+15:16];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx     <= 33'(coord_x) - 33'(origin_x);
      dz     <= 33'(coord_z) - 33'(origin_z);
      ycoord <= coord_y;
    end
    if (cmd.mul_x) prod <= 64'(dx[31:0]) * 64'(inv_x);
    if (cmd.mul_z) begin
      prod <= 64'(dz[31:0]) * 64'(inv_z);
      lx   <= clamp_coord(prod, dx_pos);
    end
    if (cmd.clamp_z) lz <= clamp_coord(prod, dz_pos);
  end

  assign dx_pos = !dx[32] && (dx != '0);
  assign dz_pos = !dz[32] && (dz != '0);

  logic [IW-1:0] x0, z0, x1, z1, cx, cz, cz_q;
  logic [15:0]   tx, tz;
  assign x0 = lx[LW-1:16];
  assign z0 = lz[LW-1:16];
  assign tx = lx[15:0];
  assign tz = lz[15:0];
  assign x1 = (x0 == LAST) ? x0 : x0 + IW'(1);
  assign z1 = (z0 == LAST) ? z0 : z0 + IW'(1);
  assign cx = cmd.rd_corner[0] ? x1 : x0;
  assign cz = cmd.rd_corner[1] ? z1 : z0;

  // memories
  logic                 h_we, m_we;
  logic [AW-1:0]        h_waddr, h_raddr;
  logic [31:0]          h_rdata;
  logic [IW-1:0]        m_waddr, m_raddr;
  logic [GRID_SIZE-1:0] m_wdata, m_rdata, row_set;
  logic [IW-1:0]        clr_cnt;
  logic                 grid_valid;

  assign h_raddr = AW'(cx) * AW'(GRID_SIZE) + AW'(cz);
  assign h_waddr = AW'(x0) * AW'(GRID_SIZE) + AW'(z0);
  assign m_raddr = cx;

  always_comb begin
    row_set     = m_rdata;
    row_set[z0] = 1'b1;
  end

  assign h_we    = cmd.wr_ins && (!m_rdata[z0] || (ycoord > $signed(h_rdata)));
  assign m_we    = cmd.wr_ins || cmd.clr_wr;
  assign m_waddr = cmd.clr_wr ? clr_cnt : x0;
  assign m_wdata = cmd.clr_wr ? '0 : row_set;

  hgm_ram #(.WIDTH(32), .DEPTH(CELLS)) u_heights (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(ycoord),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  hgm_ram #(.WIDTH(GRID_SIZE), .DEPTH(GRID_SIZE)) u_marks (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      grid_valid <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt    <= (clr_cnt == LAST) ? '0 : clr_cnt + IW'(1);
        grid_valid <= 1'b0;
      end
      if (cmd.wr_ins) grid_valid <= 1'b1;
    end
  end

  assign stat.grid_valid = grid_valid;
  assign stat.clr_last   = (clr_cnt == LAST);

  // corner capture; unsampled cells read the fallback height
  logic signed [31:0] corner [4];
  always_ff @(posedge clk) begin
    if (cmd.rd) cz_q <= cz;
    if (cmd.cap) corner[cmd.cap_corner] <= m_rdata[cz_q] ? $signed(h_rdata) : fallback;
  end

  // blend: lo + floor((hi - lo) * t / 2^16)
  logic signed [31:0] lo, hi, a_reg, b_reg;
  logic        [15:0] t;
  logic signed [32:0] diff;
  logic signed [49:0] lprod;
  logic signed [33:0] lsum;

  always_comb begin
    case (cmd.lerp_sel)
      LERP_A: begin lo = corner[0]; hi = corner[1]; t = tx; end
      LERP_B: begin lo = corner[2]; hi = corner[3]; t = tx; end
      default: begin lo = a_reg; hi = b_reg; t = tz; end
    endcase
  end

  assign lsum = 34'(lo) + 34'(lprod >>> 16);

  always_ff @(posedge clk) begin
    if (cmd.lerp_d) diff <= 33'(hi) - 33'(lo);
    if (cmd.lerp_m) lprod <= 50'(diff) * 50'($signed({1'b0, t}));
    if (cmd.lerp_a) begin
      case (cmd.lerp_sel)
        LERP_A: a_reg <= lsum[31:0];
        LERP_B: b_reg <= lsum[31:0];
        default: begin
          height_value   <= lsum[31:0];
          grid_was_valid <= 1'b1;
        end
      endcase
    end
    if (cmd.res_zero) begin
      height_value   <= '0;
      grid_was_valid <= 1'b0;
    end
  end

endmodule

### tb/tb.sv
// Testbench for the height grid engine: max-Y insert and bilinear query.
`timescale 1ns / 1ps
module tb;
  import hgm_pkg::*;

  localparam int GS = 64;
  localparam int CELL_COUNT = GS * GS;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] action = ACT_CLEAR;
  logic signed [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic done;
  logic signed [31:0] height_value;
  logic grid_was_valid;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_ORIGIN_X;
  logic [31:0] cfg_data = '0;

  height_grid_max_raster_bilinear_top #(.GRID_SIZE(GS)) dut (.*);

  always #4 clk = ~clk;

  // predictor copy of registers and grid
  logic signed [31:0] m_origin_x, m_origin_z, m_fallback;
  logic [31:0] m_inv_x, m_inv_z;
  logic signed [31:0] m_heights [CELL_COUNT];
  bit m_marks [CELL_COUNT];
  bit m_valid;

  typedef struct {
    logic signed [31:0] height;
    logic valid;
  } height_result_t;
  height_result_t expected_heights[$];

  int mismatches = 0;
  int idle_cycles = 0;
  bit allow_gaps = 1'b1;

  function automatic logic [31:0] map_coord(logic signed [31:0] c, logic signed [31:0] o,
                                            logic [31:0] inv);
    logic signed [33:0] d;
    logic [65:0] prod;
    logic [63:0] loc;
    d = $signed({c[31], c}) - $signed({o[31], o});
    if (d <= 0) return '0;
    prod = {33'd0, d[32:0]} * {34'd0, inv};
    loc = 64'(prod[65:16]);
    if (loc > 64'((GS - 1) * 65536)) return 32'((GS - 1) * 65536);
    return loc[31:0];
  endfunction

  function automatic logic signed [63:0] cell_height(int x, int z);
    if (m_marks[x * GS + z]) return 64'(m_heights[x * GS + z]);
    return 64'(m_fallback);
  endfunction

  function automatic logic signed [63:0] blend(logic signed [63:0] a, logic signed [63:0] b,
                                               logic [15:0] t);
    logic signed [63:0] p;
    p = (b - a) * $signed({48'd0, t});
    return a + (p >>> 16);
  endfunction

  function automatic void predict_word(logic [1:0] act, logic signed [31:0] x,
                                       logic signed [31:0] y, logic signed [31:0] z);
    logic [31:0] lx, lz;
    int x0, z0, x1, z1;
    logic signed [63:0] a, b, h;
    height_result_t r;
    lx = map_coord(x, m_origin_x, m_inv_x);
    lz = map_coord(z, m_origin_z, m_inv_z);
    x0 = int'(lx[31:16]);
    z0 = int'(lz[31:16]);
    case (act)
      ACT_CLEAR: begin
        foreach (m_marks[i]) m_marks[i] = 1'b0;
        m_valid = 1'b0;
      end
      ACT_INSERT: begin
        if (!m_marks[x0 * GS + z0] || y > m_heights[x0 * GS + z0])
          m_heights[x0 * GS + z0] = y;
        m_marks[x0 * GS + z0] = 1'b1;
        m_valid = 1'b1;
      end
      ACT_QUERY: begin
        h = 0;
        if (m_valid) begin
          x1 = (x0 + 1 > GS - 1) ? GS - 1 : x0 + 1;
          z1 = (z0 + 1 > GS - 1) ? GS - 1 : z0 + 1;
          a = blend(cell_height(x0, z0), cell_height(x1, z0), lx[15:0]);
          b = blend(cell_height(x0, z1), cell_height(x1, z1), lx[15:0]);
          h = blend(a, b, lz[15:0]);
        end
        r.height = h[31:0];
        r.valid = m_valid;
        expected_heights.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // start stays high after the accept until the next word or drain lowers it
  task automatic send_word(logic [1:0] act, logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z);
    int gap;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    action <= act;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    do @(posedge clk); while (busy);
    predict_word(act, x, y, z);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_heights.size() != 0 || busy) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // only called while idle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_ORIGIN_X:   m_origin_x = val;
      REG_ORIGIN_Z:   m_origin_z = val;
      REG_INV_CELL_X: m_inv_x = val;
      REG_INV_CELL_Z: m_inv_z = val;
      default:        m_fallback = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_grid(logic [31:0] ox, logic [31:0] oz, logic [31:0] ix, logic [31:0] iz,
                          logic [31:0] fb);
    drain();
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_INV_CELL_X, ix);
    write_reg(REG_INV_CELL_Z, iz);
    write_reg(REG_FALLBACK, fb);
  endtask

  // word in grid units with random fraction, slightly off both edges
  function automatic logic [31:0] on_grid();
    return ($urandom_range(0, GS + 1) - 1) * 65536 + $urandom_range(0, 65535);
  endfunction

  task automatic test_directed();
    send_word(ACT_QUERY, 0, 0, 0);
    send_word(ACT_INSERT, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    send_word(ACT_INSERT, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    send_word(ACT_INSERT, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    send_word(ACT_INSERT, 32'h0001_8000, 32'h0005_0000, 32'h0002_0000);
    send_word(ACT_INSERT, 32'h0001_8000, 32'h0005_0000, 32'h0002_0000);
    send_word(ACT_INSERT, 32'h0001_8000, 32'h0003_0000, 32'h0002_0000);
    send_word(ACT_QUERY, 32'h0001_8000, 0, 32'h0002_4000);
    send_word(ACT_QUERY, 32'h0000_ffff, 0, 32'h0001_ffff);
    send_word(ACT_QUERY, 32'sh8000_0000, 0, 32'sh7fff_ffff);
    send_word(ACT_QUERY, 32'sh7fff_ffff, 0, 32'sh8000_0000);
    send_word(ACT_NOP, 32'h0001_0000, 32'h1234_5678, 32'h0002_0000);
    send_word(ACT_QUERY, 32'h003e_8000, 0, 32'h003e_8000);
    send_word(ACT_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_word(ACT_QUERY, 32'h0001_8000, 0, 32'h0002_4000);
    set_grid(32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'hffff_ffff, 32'h8000_0000);
    send_word(ACT_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(ACT_QUERY, 32'h0, 0, 32'h7fff_ffff);
    send_word(ACT_QUERY, 32'h7fff_ffff, 0, 32'h8000_0000);
  endtask

  task automatic test_random(int n, logic [31:0] ox, logic [31:0] oz, logic [31:0] ix,
                             logic [31:0] iz, logic [31:0] fb);
    int pick;
    logic [1:0] act;
    logic [31:0] x, z;
    set_grid(ox, oz, ix, iz, fb);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      act = pick < 2 ? ACT_CLEAR : pick < 50 ? ACT_INSERT : pick < 97 ? ACT_QUERY : ACT_NOP;
      if ($urandom_range(0, 9) == 0) begin
        x = $urandom();
        z = $urandom();
      end else begin
        // with inv 1.0 these land across the grid
        x = ox + on_grid();
        z = oz + on_grid();
      end
      send_word(act, x, $urandom(), z);
    end
  endtask

  initial begin
    m_origin_x = 0; m_origin_z = 0; m_inv_x = 32'h1_0000; m_inv_z = 32'h1_0000;
    m_fallback = 0; m_valid = 1'b0;
    foreach (m_marks[i]) m_marks[i] = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(500, 32'h0, 32'h0, 32'h1_0000, 32'h1_0000, 32'hfffe_0000);
    test_random(400, 32'hffe0_0000, 32'h0010_8000, 32'h1_0000, 32'h1_0000, 32'h7fff_ffff);
    test_random(400, 32'h0, 32'h0, 32'h0_4000, 32'h4_0000, 32'h0003_2000);
    test_random(300, 32'h7fff_0000, 32'h8000_0000, 32'h1_0000, 32'h1_0000, 32'h0);
    allow_gaps = 1'b0;
    test_random(330, 32'h0, 32'h0, 32'h1_0000, 32'h1_0000, 32'h0001_0000);
    drain();
    if (mismatches == 0 && expected_heights.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    height_result_t e;
    if (!rst && done) begin
      if (expected_heights.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: height %0d valid %0d",
                                       height_value, grid_was_valid);
      end else begin
        e = expected_heights.pop_front();
        if (e.height !== height_value || e.valid !== grid_was_valid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp height %0d valid %0d, got height %0d valid %0d",
                     e.height, e.valid, height_value, grid_was_valid);
        end
      end
    end
  end

  // counts cycles in which no word moves either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we || !start && expected_heights.size() == 0)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end
endmodule
